/* rtl/bps_pkg.sv */
// Shared types, constants and helper functions of the byte pattern search block.
package bps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 5;
    localparam int OFFS_W      = 48;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [OFFS_W-1:0] OFFS_MAX = {OFFS_W{1'b1}};

    typedef logic [CFG_IDX_W-1:0]              t_cfg_idx;
    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] t_window;
    typedef logic [LEN_W-1:0]                  t_len;
    typedef logic [OFFS_W-1:0]                 t_offs;

    localparam t_cfg_idx CFG_PATTERN_LOW      = 3'd0;
    localparam t_cfg_idx CFG_PATTERN_HIGH     = 3'd1;
    localparam t_cfg_idx CFG_PATTERN_LENGTH   = 3'd2;
    localparam t_cfg_idx CFG_CASE_INSENSITIVE = 3'd3;
    localparam t_cfg_idx CFG_START_OFFSET     = 3'd4;

    // ASCII upper case to lower when folding is on
    function automatic logic [BYTE_W-1:0] fold(input logic ci, input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ci && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Length in use: zero acts as one, oversize clamps to the window depth
    function automatic t_len eff_len(input t_len len);
        t_len r;
        r = len;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(MAX_PATTERN)) begin
            r = LEN_W'(MAX_PATTERN);
        end
        return r;
    endfunction

endpackage

/* rtl/bps_in_if.sv */
// Input channel of the byte pattern search block: one data byte per item.
interface bps_in_if;
    logic                      valid;
    logic                      ready;
    logic [bps_pkg::BYTE_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/bps_out_if.sv */
// Result channel of the byte pattern search block.
interface bps_out_if;
    logic                 valid;
    logic                 ready;
    logic                 found;
    bps_pkg::t_offs       match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* rtl/bps_match.sv */
// Parallel compare of the newest window bytes with the configured pattern.
module bps_match (
    input  logic             i_ci,
    input  bps_pkg::t_window i_win,
    input  bps_pkg::t_window i_pat,
    input  bps_pkg::t_len    i_len,
    output logic             o_eq
);

    logic [bps_pkg::MAX_PATTERN-1:0] w_eq;

    always_comb begin
        logic [bps_pkg::LEN_W-1:0] sel;
        for (int i = 0; i < bps_pkg::MAX_PATTERN; i++) begin
            // pattern byte i lines up with window slot depth - len + i
            sel = bps_pkg::LEN_W'(bps_pkg::MAX_PATTERN) - i_len + bps_pkg::LEN_W'(i);
            w_eq[i] = (bps_pkg::LEN_W'(i) >= i_len) ||
                      (bps_pkg::fold(i_ci, i_win[sel[bps_pkg::IDX_W-1:0]]) ==
                       bps_pkg::fold(i_ci, i_pat[i]));
        end
    end

    assign o_eq = &w_eq;

endmodule

/* rtl/byte_pattern_search_core.sv */
// Byte pattern search: first match of a pattern of up to 16 bytes in a byte stream.
// The block takes one data byte per cycle with no gaps of its own. Each byte is
// shifted into a 16-byte window and compared with the pattern in the cycle it is
// accepted; a result (match or end of range without match) goes into a stage register
// at the accepting edge and moves on into the output register once that register is
// free, after the offset sum. Throughput is one byte per clock, set by the window compare;
// stalls on the result side hold the input only once both pipeline registers are full.
// After a match the bytes up to last_byte are taken and dropped; last_byte always
// restarts the search.
module byte_pattern_search_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bps_in_if.sink                              i_in,
    bps_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  bps_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]           i_cfg_data
);

    // configuration registers
    logic [bps_pkg::CFG_W-1:0] r_pat_lo;
    logic [bps_pkg::CFG_W-1:0] r_pat_hi;
    bps_pkg::t_len             r_pat_len;
    logic                      r_ci;
    bps_pkg::t_offs            r_start;

    // search state
    bps_pkg::t_window r_win, n_win;
    bps_pkg::t_offs   r_cnt, n_cnt;
    logic             r_done, n_done;

    // result pipeline
    logic           r_s1_valid;
    logic           r_s1_found;
    bps_pkg::t_offs r_s1_before;
    logic           r_o_valid;
    logic           r_o_found;
    bps_pkg::t_offs r_o_offset;

    logic             w_acc;
    logic             w_adv2;
    bps_pkg::t_window w_shift;
    bps_pkg::t_window w_pat;
    bps_pkg::t_len    w_len;
    bps_pkg::t_offs   w_cnt_inc;
    logic             w_eq;
    logic             w_match;
    logic             w_result;
    logic [bps_pkg::OFFS_W:0] w_sum;

    assign w_adv2     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv2;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_shift   = bps_pkg::t_window'({i_in.data_byte, r_win[bps_pkg::MAX_PATTERN-1:1]});
    assign w_pat     = bps_pkg::t_window'({r_pat_hi, r_pat_lo});
    assign w_len     = bps_pkg::eff_len(r_pat_len);
    assign w_cnt_inc = (r_cnt == bps_pkg::OFFS_MAX) ? r_cnt : r_cnt + 1'b1;

    bps_match u_match (
        .i_ci  (r_ci),
        .i_win (w_shift),
        .i_pat (w_pat),
        .i_len (w_len),
        .o_eq  (w_eq)
    );

    // a match has to lie wholly inside the bytes of this search
    assign w_match  = w_eq && (w_cnt_inc >= bps_pkg::OFFS_W'(w_len));
    assign w_result = w_acc && !r_done && (w_match || i_in.last_byte);

    always_comb begin
        n_win  = r_win;
        n_cnt  = r_cnt;
        n_done = r_done;
        if (w_acc) begin
            if (i_in.last_byte) begin
                n_win  = '0;
                n_cnt  = '0;
                n_done = 1'b0;
            end else if (!r_done) begin
                n_win  = w_shift;
                n_cnt  = w_cnt_inc;
                n_done = w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= bps_pkg::LEN_W'(1);
            r_ci      <= 1'b0;
            r_start   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bps_pkg::CFG_PATTERN_LOW:      r_pat_lo  <= i_cfg_data;
                bps_pkg::CFG_PATTERN_HIGH:     r_pat_hi  <= i_cfg_data;
                bps_pkg::CFG_PATTERN_LENGTH:   r_pat_len <= i_cfg_data[bps_pkg::LEN_W-1:0];
                bps_pkg::CFG_CASE_INSENSITIVE: r_ci      <= i_cfg_data[0];
                bps_pkg::CFG_START_OFFSET:     r_start   <= i_cfg_data[bps_pkg::OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_cnt      <= '0;
            r_done     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_cnt  <= n_cnt;
            r_done <= n_done;
            if (w_acc || w_adv2) begin
                r_s1_valid <= w_result;
            end
            if (w_adv2) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign w_sum = {1'b0, r_start} + {1'b0, r_s1_before};

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_found  <= w_match;
            r_s1_before <= w_cnt_inc - bps_pkg::OFFS_W'(w_len);
        end
        if (w_adv2) begin
            r_o_found <= r_s1_found;
            if (!r_s1_found) begin
                r_o_offset <= '0;
            end else if (w_sum[bps_pkg::OFFS_W]) begin
                r_o_offset <= bps_pkg::OFFS_MAX;
            end else begin
                r_o_offset <= w_sum[bps_pkg::OFFS_W-1:0];
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.found        = r_o_found;
    assign o_out.match_offset = r_o_offset;

endmodule

/* rtl/bps_checker.sv */
// Port-level checks of the byte pattern search block, bound to the top level.
module bps_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input logic           i_out_found,
    input bps_pkg::t_offs i_out_offset
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_found) && $stable(i_out_offset))
        else $error("result item changed while stalled");

    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_offset == '0)
        else $error("offset not zero on a no-match result");

    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid straight after reset");

    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output register");

endmodule

bind byte_pattern_search_core bps_checker u_bps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_found  (o_out.found),
    .i_out_offset (o_out.match_offset)
);
